// ===== design/pdt_pkg.sv =====
// Shared types, constants and microcode program of the periodic deadline tracker.
package pdt_pkg;

    localparam int TimeW     = 32;
    localparam int CountW    = 16;
    localparam int ModeW     = 2;
    localparam int StepW     = 4;
    localparam int DivCntW   = 5;
    localparam int ApbAddrW  = 4;
    localparam int ApbDataW  = 32;

    // Last value of the divider step counter: one quotient bit per step.
    localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(TimeW - 1);

    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [TimeW-1:0]  ElapsedClampReset = '1;

    // Item modes.
    localparam logic [ModeW-1:0] MODE_START   = 2'd0;
    localparam logic [ModeW-1:0] MODE_POLL    = 2'd1;
    localparam logic [ModeW-1:0] MODE_ELAPSED = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PERIOD      = 2'd0;
    localparam logic [1:0] REG_PHASE       = 2'd1;
    localparam logic [1:0] REG_MAX_ELAPSED = 2'd2;

    typedef logic [StepW-1:0] step_t;

    // Program addresses.
    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DECODE   = 4'd1;
    localparam step_t STEP_CHK_ELAP = 4'd2;
    localparam step_t STEP_CHK_POLL = 4'd3;
    localparam step_t STEP_CHK_DUE  = 4'd4;
    localparam step_t STEP_DIV_INIT = 4'd5;
    localparam step_t STEP_DIV_LOOP = 4'd6;
    localparam step_t STEP_DL_PREP  = 4'd7;
    localparam step_t STEP_POLL_UPD = 4'd8;
    localparam step_t STEP_START    = 4'd11;
    localparam step_t STEP_ELAPSED  = 4'd12;
    localparam step_t STEP_EMIT     = 4'd13;
    localparam step_t STEP_RETURN   = 4'd14;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DL_PREP,
        OP_POLL_UPD,
        OP_START,
        OP_ELAPSED,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_ACCEPT,
        JC_MODE_START,
        JC_MODE_ELAPSED,
        JC_NOT_POLL,
        JC_NOT_DUE,
        JC_PERIOD_ZERO,
        JC_DIV_BUSY,
        JC_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Microcode program. A step jumps to its target when its condition holds,
    // otherwise it falls through to the next address.
    function automatic ctrl_word_t ucode_rom(input step_t pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: JC_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:     w = '{op: OP_NOP,      cond: JC_NO_ACCEPT,    target: STEP_IDLE};
            STEP_DECODE:   w = '{op: OP_LATE,     cond: JC_MODE_START,   target: STEP_START};
            STEP_CHK_ELAP: w = '{op: OP_NOP,      cond: JC_MODE_ELAPSED, target: STEP_ELAPSED};
            STEP_CHK_POLL: w = '{op: OP_NOP,      cond: JC_NOT_POLL,     target: STEP_EMIT};
            STEP_CHK_DUE:  w = '{op: OP_NOP,      cond: JC_NOT_DUE,      target: STEP_EMIT};
            STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: JC_PERIOD_ZERO,  target: STEP_DL_PREP};
            STEP_DIV_LOOP: w = '{op: OP_DIV_STEP, cond: JC_DIV_BUSY,     target: STEP_DIV_LOOP};
            STEP_DL_PREP:  w = '{op: OP_DL_PREP,  cond: JC_NEVER,        target: STEP_IDLE};
            STEP_POLL_UPD: w = '{op: OP_POLL_UPD, cond: JC_ALWAYS,       target: STEP_EMIT};
            STEP_START:    w = '{op: OP_START,    cond: JC_ALWAYS,       target: STEP_EMIT};
            STEP_ELAPSED:  w = '{op: OP_ELAPSED,  cond: JC_ALWAYS,       target: STEP_EMIT};
            STEP_EMIT:     w = '{op: OP_EMIT,     cond: JC_OUT_BUSY,     target: STEP_EMIT};
            STEP_RETURN:   w = '{op: OP_NOP,      cond: JC_ALWAYS,       target: STEP_IDLE};
            default:       w = '{op: OP_NOP,      cond: JC_ALWAYS,       target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Adds a 32-bit increment to a 16-bit counter, saturating at its maximum.
    function automatic logic [CountW-1:0] sat_add16(input logic [CountW-1:0] base,
                                                    input logic [TimeW-1:0] inc);
        logic [CountW:0] sum;
        sum = {1'b0, base} + {1'b0, inc[CountW-1:0]};
        if (inc[TimeW-1:CountW] != '0 || sum[CountW]) begin
            return CountMax;
        end
        return sum[CountW-1:0];
    endfunction

endpackage

// ===== design/periodic_deadline_tracker_core.sv =====
// Top level of the periodic deadline tracker: microcoded sequencer, datapath and APB registers.
//
// Usage: the block follows one periodic task against a free-running 32-bit
// microsecond clock. Each input transfer (s_valid/s_ready) carries a mode and
// the current time s_now_us: start arms the task, poll checks the deadline,
// elapsed measures the time since the previous elapsed query. Every input
// transfer produces exactly one result transfer on m_valid/m_ready.
// Configuration (period, phase, elapsed clamp) is written over the APB port at
// byte addresses 0, 4 and 8 while no item is in flight; pready is always high.
// The sequencer runs one microcode step per cycle. A start goes through decode, start
// and emit; an elapsed query through decode, the elapsed check, elapsed and emit. An
// unused mode or a poll that is not due goes from its checks to emit. A due poll runs
// the divider init, the restoring divider for 32 steps (one quotient bit each) unless the
// period is zero, then deadline preparation, poll update and emit; return and idle follow.
// The block takes one item at a time: s_ready is high only at the idle step.
// When the receiver stalls, the finished result waits in the output register
// and the next item is accepted and worked on; that item only waits at its
// emit step until the output register is free.
// Reset (aresetn low, synchronous) returns the sequencer to idle, empties the
// output register, disarms the task and restores the configuration defaults.
module periodic_deadline_tracker_core
    import pdt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ModeW-1:0]     s_mode,
    input  logic [TimeW-1:0]     s_now_us,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_due,
    output logic [TimeW-1:0]     m_lateness_us,
    output logic [TimeW-1:0]     m_max_lateness_us,
    output logic [CountW-1:0]    m_missed_total,
    output logic [CountW-1:0]    m_consecutive_misses,
    output logic [TimeW-1:0]     m_elapsed_us,
    output logic [TimeW-1:0]     m_until_deadline_us,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ApbAddrW-1:0]  paddr,
    input  logic [ApbDataW-1:0]  pwdata,
    output logic [ApbDataW-1:0]  prdata,
    output logic                 pready
);

    // Sequencer
    step_t              pc_reg, pc_next;
    ctrl_word_t         cw;
    logic               jump;

    // Configuration registers
    logic [TimeW-1:0]   period_reg, period_next;
    logic [TimeW-1:0]   phase_reg, phase_next;
    logic [TimeW-1:0]   max_elapsed_reg, max_elapsed_next;

    // Captured item
    logic [ModeW-1:0]   mode_reg, mode_next;
    logic [TimeW-1:0]   now_reg, now_next;

    // Task state
    logic               armed_reg, armed_next;
    logic [TimeW-1:0]   deadline_reg, deadline_next;
    logic [TimeW-1:0]   last_run_reg, last_run_next;
    logic [TimeW-1:0]   last_late_reg, last_late_next;
    logic [TimeW-1:0]   peak_late_reg, peak_late_next;
    logic [CountW-1:0]  missed_reg, missed_next;
    logic [CountW-1:0]  streak_reg, streak_next;

    // Per-item working registers
    logic [TimeW-1:0]   late_reg, late_next;
    logic [TimeW-1:0]   rem_reg, rem_next;
    logic [TimeW-1:0]   quo_reg, quo_next;
    logic [DivCntW-1:0] div_cnt_reg, div_cnt_next;
    logic               due_reg, due_next;
    logic [TimeW-1:0]   elapsed_reg, elapsed_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic               o_due_reg, o_due_next;
    logic [TimeW-1:0]   o_late_reg, o_late_next;
    logic [TimeW-1:0]   o_peak_reg, o_peak_next;
    logic [CountW-1:0]  o_missed_reg, o_missed_next;
    logic [CountW-1:0]  o_streak_reg, o_streak_next;
    logic [TimeW-1:0]   o_elapsed_reg, o_elapsed_next;
    logic [TimeW-1:0]   o_left_reg, o_left_next;

    logic               in_xfer;
    logic               out_busy;
    logic               cfg_write;
    logic [TimeW:0]     div_trial;
    logic [TimeW-1:0]   elapsed_raw;
    logic [TimeW-1:0]   left_raw;

    assign s_ready   = (pc_reg == STEP_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_busy  = m_valid_reg && !m_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    assign cw = ucode_rom(pc_reg);

    // Branch condition selected by the current control word.
    always_comb begin
        case (cw.cond)
            JC_NEVER:        jump = 1'b0;
            JC_ALWAYS:       jump = 1'b1;
            JC_NO_ACCEPT:    jump = !in_xfer;
            JC_MODE_START:   jump = (mode_reg == MODE_START);
            JC_MODE_ELAPSED: jump = (mode_reg == MODE_ELAPSED);
            JC_NOT_POLL:     jump = (mode_reg != MODE_POLL);
            JC_NOT_DUE:      jump = !armed_reg || late_reg[TimeW-1];
            JC_PERIOD_ZERO:  jump = (period_reg == '0);
            JC_DIV_BUSY:     jump = (div_cnt_reg != DivLastStep);
            JC_OUT_BUSY:     jump = out_busy;
            default:         jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : pc_reg + step_t'(1);
    end

    // One restoring division step: shift in the next dividend bit and try the subtract.
    assign div_trial   = {rem_reg, quo_reg[TimeW-1]} - {1'b0, period_reg};
    assign elapsed_raw = now_reg - last_run_reg;
    assign left_raw    = deadline_reg - now_reg;

    // Datapath, driven by the op field of the control word.
    always_comb begin
        period_next      = period_reg;
        phase_next       = phase_reg;
        max_elapsed_next = max_elapsed_reg;
        mode_next        = mode_reg;
        now_next         = now_reg;
        armed_next       = armed_reg;
        deadline_next    = deadline_reg;
        last_run_next    = last_run_reg;
        last_late_next   = last_late_reg;
        peak_late_next   = peak_late_reg;
        missed_next      = missed_reg;
        streak_next      = streak_reg;
        late_next        = late_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        div_cnt_next     = div_cnt_reg;
        due_next         = due_reg;
        elapsed_next     = elapsed_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        o_due_next       = o_due_reg;
        o_late_next      = o_late_reg;
        o_peak_next      = o_peak_reg;
        o_missed_next    = o_missed_reg;
        o_streak_next    = o_streak_reg;
        o_elapsed_next   = o_elapsed_reg;
        o_left_next      = o_left_reg;

        if (cfg_write) begin
            case (paddr[3:2])
                REG_PERIOD:      period_next      = pwdata[TimeW-1:0];
                REG_PHASE:       phase_next       = pwdata[TimeW-1:0];
                REG_MAX_ELAPSED: max_elapsed_next = pwdata[TimeW-1:0];
                default:         ;
            endcase
        end

        if (in_xfer) begin
            mode_next    = s_mode;
            now_next     = s_now_us;
            due_next     = 1'b0;
            elapsed_next = '0;
        end

        unique case (cw.op)
            OP_NOP: ;
            OP_LATE: begin
                late_next = now_reg - deadline_reg;
            end
            OP_DIV_INIT: begin
                // With zero period the quotient is zero and the whole lateness
                // stays as remainder, so the deadline comes out unchanged.
                div_cnt_next = '0;
                if (period_reg == '0) begin
                    quo_next = '0;
                    rem_next = late_reg;
                end else begin
                    quo_next = late_reg;
                    rem_next = '0;
                end
            end
            OP_DIV_STEP: begin
                div_cnt_next = div_cnt_reg + DivCntW'(1);
                if (!div_trial[TimeW]) begin
                    rem_next = div_trial[TimeW-1:0];
                    quo_next = {quo_reg[TimeW-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[TimeW-2:0], quo_reg[TimeW-1]};
                    quo_next = {quo_reg[TimeW-2:0], 1'b0};
                end
            end
            OP_DL_PREP: begin
                // deadline + (missed + 1) * period equals now - remainder + period.
                rem_next = now_reg - rem_reg;
            end
            OP_POLL_UPD: begin
                due_next       = 1'b1;
                last_late_next = late_reg;
                if (late_reg > peak_late_reg) begin
                    peak_late_next = late_reg;
                end
                if (quo_reg != '0) begin
                    missed_next = sat_add16(missed_reg, quo_reg);
                    streak_next = sat_add16(streak_reg, quo_reg);
                end else begin
                    streak_next = '0;
                end
                deadline_next = rem_reg + period_reg;
            end
            OP_START: begin
                deadline_next  = now_reg + phase_reg;
                last_run_next  = now_reg;
                last_late_next = '0;
                peak_late_next = '0;
                missed_next    = '0;
                streak_next    = '0;
                armed_next     = 1'b1;
            end
            OP_ELAPSED: begin
                last_run_next = now_reg;
                elapsed_next  = (elapsed_raw > max_elapsed_reg) ? max_elapsed_reg : elapsed_raw;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next   = 1'b1;
                    o_due_next     = due_reg;
                    o_late_next    = last_late_reg;
                    o_peak_next    = peak_late_reg;
                    o_missed_next  = missed_reg;
                    o_streak_next  = streak_reg;
                    o_elapsed_next = elapsed_reg;
                    o_left_next    = (left_raw == '0 || left_raw[TimeW-1]) ? '0 : left_raw;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= STEP_IDLE;
            m_valid_reg     <= 1'b0;
            period_reg      <= '0;
            phase_reg       <= '0;
            max_elapsed_reg <= ElapsedClampReset;
            armed_reg       <= 1'b0;
            deadline_reg    <= '0;
            last_run_reg    <= '0;
            last_late_reg   <= '0;
            peak_late_reg   <= '0;
            missed_reg      <= '0;
            streak_reg      <= '0;
        end else begin
            pc_reg          <= pc_next;
            m_valid_reg     <= m_valid_next;
            period_reg      <= period_next;
            phase_reg       <= phase_next;
            max_elapsed_reg <= max_elapsed_next;
            armed_reg       <= armed_next;
            deadline_reg    <= deadline_next;
            last_run_reg    <= last_run_next;
            last_late_reg   <= last_late_next;
            peak_late_reg   <= peak_late_next;
            missed_reg      <= missed_next;
            streak_reg      <= streak_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        now_reg       <= now_next;
        late_reg      <= late_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_cnt_reg   <= div_cnt_next;
        due_reg       <= due_next;
        elapsed_reg   <= elapsed_next;
        o_due_reg     <= o_due_next;
        o_late_reg    <= o_late_next;
        o_peak_reg    <= o_peak_next;
        o_missed_reg  <= o_missed_next;
        o_streak_reg  <= o_streak_next;
        o_elapsed_reg <= o_elapsed_next;
        o_left_reg    <= o_left_next;
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_PERIOD:      prdata = ApbDataW'(period_reg);
            REG_PHASE:       prdata = ApbDataW'(phase_reg);
            REG_MAX_ELAPSED: prdata = ApbDataW'(max_elapsed_reg);
            default:         prdata = '0;
        endcase
    end

    assign m_valid              = m_valid_reg;
    assign m_is_due             = o_due_reg;
    assign m_lateness_us        = o_late_reg;
    assign m_max_lateness_us    = o_peak_reg;
    assign m_missed_total       = o_missed_reg;
    assign m_consecutive_misses = o_streak_reg;
    assign m_elapsed_us         = o_elapsed_reg;
    assign m_until_deadline_us  = o_left_reg;

    // An accepted item always continues at the decode step.
    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> pc_reg == STEP_DECODE)
        else $error("accepted item did not reach the decode step");

    // The restoring divider keeps its partial remainder below the divisor.
    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == STEP_DIV_LOOP |-> rem_reg < period_reg)
        else $error("divider remainder not below the period");

    // A due poll never reports more lateness than the recorded peak.
    a_peak_covers_late: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && o_due_reg |-> o_late_reg <= o_peak_reg)
        else $error("lateness exceeds the peak lateness");

    // The miss streak is a part of the total misses.
    a_streak_in_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> o_streak_reg <= o_missed_reg)
        else $error("miss streak exceeds total misses");

    // The reported elapsed time respects the clamp.
    a_elapsed_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> o_elapsed_reg <= max_elapsed_reg)
        else $error("elapsed time above the clamp");

endmodule
